// ===== rtl/xtea3_pkg.sv =====
`default_nettype none
package xtea3_pkg;

  localparam int MAX_ROUNDS = 64;
  localparam int EFF_W = $clog2(MAX_ROUNDS + 1);
  localparam logic [31:0] DELTA = 32'h9E3779B9;
  localparam logic [6:0] DEFAULT_ROUNDS = 7'd48;

  typedef enum logic [2:0] {
    REG_KEY_01 = 3'd0,
    REG_KEY_23 = 3'd1,
    REG_KEY_45 = 3'd2,
    REG_KEY_67 = 3'd3,
    REG_ROUNDS = 3'd4
  } reg_index_t;

  typedef logic [7:0][31:0] key_t;
  typedef logic [3:0][31:0] block_t;

  typedef struct packed {
    logic        dec;
    logic [31:0] sum;
    block_t      w;
  } stage_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] amt);
    logic [5:0] rev;
    rev = 6'd32 - {1'b0, amt};
    return (amt == 5'd0) ? x : ((x << amt) | (x >> rev));
  endfunction

  function automatic logic [31:0] mix(input key_t kw, input logic [31:0] x,
                                     input logic [31:0] y, input logic [31:0] s,
                                     input logic [1:0] sel);
    logic [31:0] p;
    logic [31:0] q;
    p = (x << 4) + rotl(kw[{1'b1, sel}], x[4:0]);
    q = (x >> 5) + rotl(kw[{1'b0, sel}], x[31:27]);
    return p ^ (y + s) ^ q;
  endfunction

  // One full round in either direction; the running sum travels with the word.
  function automatic stage_t round_step(input key_t kw, input stage_t st);
    stage_t      r;
    logic [31:0] a, b, c, d, s1;
    r = st;
    if (!st.dec) begin
      a  = st.w[0] + mix(kw, st.w[1], st.w[3], st.sum, st.sum[1:0]);
      s1 = st.sum + DELTA;
      c  = st.w[2] + mix(kw, st.w[3], st.w[1], s1, s1[12:11]);
      r.w[0] = st.w[1];
      r.w[1] = c;
      r.w[2] = st.w[3];
      r.w[3] = a;
      r.sum  = s1;
    end else begin
      a = st.w[3];
      b = st.w[0];
      c = st.w[1];
      d = st.w[2];
      c  = c - mix(kw, d, b, st.sum, st.sum[12:11]);
      s1 = st.sum - DELTA;
      a  = a - mix(kw, b, d, s1, s1[1:0]);
      r.w[0] = a;
      r.w[1] = b;
      r.w[2] = c;
      r.w[3] = d;
      r.sum  = s1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/xtea3_if.sv =====
`default_nettype none
interface xtea3_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] block_word0;
  logic [31:0] block_word1;
  logic [31:0] block_word2;
  logic [31:0] block_word3;
  modport source (output valid, req_type, block_word0, block_word1, block_word2,
                  block_word3, input ready);
  modport sink (input valid, req_type, block_word0, block_word1, block_word2,
                block_word3, output ready);
endinterface

interface xtea3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word0;
  logic [31:0] out_word1;
  logic [31:0] out_word2;
  logic [31:0] out_word3;
  modport source (output valid, out_word0, out_word1, out_word2, out_word3, input ready);
  modport sink (input valid, out_word0, out_word1, out_word2, out_word3, output ready);
endinterface

interface xtea3_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/xtea3_block_cipher.sv =====
// XTEA3 block cipher, 128-bit block and 256-bit key.
// Channel blk_in carries one block per handshake: req_type (0 encipher,
// 1 decipher) and the four block words. Channel blk_out returns the result
// words. Channel cfg writes the key registers (indices 0 to 3) and the round
// count (index 4); writes to other indices are dropped. cfg is always ready.
// Configuration must only be changed while no block is in flight.
// The datapath is a pipeline of one whitening stage, one stage per round up
// to 64 rounds, and an output stage. Stages beyond the programmed round count
// pass the word through, so every block crosses all stages whatever the
// round count. Throughput is one block per cycle while no stall holds it.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and blk_in.ready drops; nothing is lost.
// Reset clears all valid bits, zeroes the key and sets the round count to 48.
`default_nettype none
module xtea3_block_cipher (
  input wire logic   clk,
  input wire logic   rst,
  xtea3_in_if.sink   blk_in,
  xtea3_out_if.source blk_out,
  xtea3_cfg_if.sink  cfg
);

  logic [63:0] key_01, key_23, key_45, key_67;
  logic [6:0]  round_count;
  xtea3_pkg::key_t kw;
  logic [xtea3_pkg::EFF_W-1:0] eff_rounds;
  logic [7:0]  rc_wide;
  logic        adv;

  xtea3_pkg::stage_t st [0:xtea3_pkg::MAX_ROUNDS];
  logic              vld [0:xtea3_pkg::MAX_ROUNDS];
  xtea3_pkg::stage_t st_in;

  logic         out_valid;
  xtea3_pkg::block_t out_w;
  xtea3_pkg::block_t fin;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_01      <= '0;
      key_23      <= '0;
      key_45      <= '0;
      key_67      <= '0;
      round_count <= xtea3_pkg::DEFAULT_ROUNDS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        xtea3_pkg::REG_KEY_01: key_01 <= cfg.data;
        xtea3_pkg::REG_KEY_23: key_23 <= cfg.data;
        xtea3_pkg::REG_KEY_45: key_45 <= cfg.data;
        xtea3_pkg::REG_KEY_67: key_67 <= cfg.data;
        xtea3_pkg::REG_ROUNDS: round_count <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  assign kw = {key_67, key_45, key_23, key_01};

  always_comb begin
    rc_wide = {1'b0, round_count};
    if (rc_wide == 8'd0) begin
      eff_rounds = xtea3_pkg::EFF_W'(1);
    end else if (rc_wide > 8'(xtea3_pkg::MAX_ROUNDS)) begin
      eff_rounds = xtea3_pkg::EFF_W'(xtea3_pkg::MAX_ROUNDS);
    end else begin
      eff_rounds = xtea3_pkg::EFF_W'(rc_wide);
    end
  end

  assign adv = !out_valid || blk_out.ready;
  assign blk_in.ready = adv;

  // Whitening at entry: key add for enciphering, key XOR for deciphering.
  always_comb begin
    st_in.dec = blk_in.req_type;
    if (!blk_in.req_type) begin
      st_in.sum  = '0;
      st_in.w[0] = blk_in.block_word0 + kw[0];
      st_in.w[1] = blk_in.block_word1 + kw[1];
      st_in.w[2] = blk_in.block_word2 + kw[2];
      st_in.w[3] = blk_in.block_word3 + kw[3];
    end else begin
      st_in.sum  = 32'(xtea3_pkg::DELTA * 32'(eff_rounds));
      st_in.w[0] = blk_in.block_word0 ^ kw[4];
      st_in.w[1] = blk_in.block_word1 ^ kw[5];
      st_in.w[2] = blk_in.block_word2 ^ kw[6];
      st_in.w[3] = blk_in.block_word3 ^ kw[7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= blk_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st_in;
    end
  end

  for (genvar k = 0; k < xtea3_pkg::MAX_ROUNDS; k++) begin : g_round
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (eff_rounds > xtea3_pkg::EFF_W'(k)) begin
          st[k+1] <= xtea3_pkg::round_step(kw, st[k]);
        end else begin
          st[k+1] <= st[k];
        end
      end
    end
  end

  always_comb begin
    if (!st[xtea3_pkg::MAX_ROUNDS].dec) begin
      fin[0] = st[xtea3_pkg::MAX_ROUNDS].w[0] ^ kw[4];
      fin[1] = st[xtea3_pkg::MAX_ROUNDS].w[1] ^ kw[5];
      fin[2] = st[xtea3_pkg::MAX_ROUNDS].w[2] ^ kw[6];
      fin[3] = st[xtea3_pkg::MAX_ROUNDS].w[3] ^ kw[7];
    end else begin
      fin[0] = st[xtea3_pkg::MAX_ROUNDS].w[0] - kw[0];
      fin[1] = st[xtea3_pkg::MAX_ROUNDS].w[1] - kw[1];
      fin[2] = st[xtea3_pkg::MAX_ROUNDS].w[2] - kw[2];
      fin[3] = st[xtea3_pkg::MAX_ROUNDS].w[3] - kw[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[xtea3_pkg::MAX_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_w <= fin;
    end
  end

  assign blk_out.valid     = out_valid;
  assign blk_out.out_word0 = out_w[0];
  assign blk_out.out_word1 = out_w[1];
  assign blk_out.out_word2 = out_w[2];
  assign blk_out.out_word3 = out_w[3];

endmodule
`default_nettype wire

// ===== verif/xtea3_checker.sv =====
module xtea3_checker (
  input wire logic clk,
  input wire logic rst,
  xtea3_in_if.sink blk_in,
  xtea3_out_if.sink blk_out,
  xtea3_cfg_if.sink cfg,
  output int errors,
  output int pending
);

  logic [31:0] key_word [8];
  logic [6:0] rounds_reg;
  xtea3_pkg::block_t expected_blocks [$];

  function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] amt);
    logic [5:0] rev;
    rev = 6'd32 - {1'b0, amt};
    if (amt == 5'd0) return x;
    return (x << amt) | (x >> rev);
  endfunction

  function automatic logic [31:0] round_mix(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] s, input logic [1:0] pick);
    logic [31:0] p;
    logic [31:0] q;
    p = (x << 4) + rot_left(key_word[{1'b1, pick}], x[4:0]);
    q = (x >> 5) + rot_left(key_word[{1'b0, pick}], x[31:27]);
    return p ^ (y + s) ^ q;
  endfunction

  function automatic xtea3_pkg::block_t cipher_block(input logic dir,
                                                     input xtea3_pkg::block_t w);
    logic [31:0] a, b, c, d, s, t;
    int n;
    xtea3_pkg::block_t r;
    n = (rounds_reg == 0) ? 1 : (rounds_reg > xtea3_pkg::MAX_ROUNDS) ? xtea3_pkg::MAX_ROUNDS
                                                                     : int'(rounds_reg);
    if (!dir) begin
      a = w[0] + key_word[0]; b = w[1] + key_word[1];
      c = w[2] + key_word[2]; d = w[3] + key_word[3];
      s = '0;
      for (int i = 0; i < n; i++) begin
        a += round_mix(b, d, s, s[1:0]);
        s += 32'h9E3779B9;
        c += round_mix(d, b, s, s[12:11]);
        t = a; a = b; b = c; c = d; d = t;
      end
      r[0] = a ^ key_word[4]; r[1] = b ^ key_word[5];
      r[2] = c ^ key_word[6]; r[3] = d ^ key_word[7];
    end else begin
      a = w[0] ^ key_word[4]; b = w[1] ^ key_word[5];
      c = w[2] ^ key_word[6]; d = w[3] ^ key_word[7];
      s = 32'(32'h9E3779B9 * 32'(n));
      for (int i = 0; i < n; i++) begin
        t = d; d = c; c = b; b = a; a = t;
        c -= round_mix(d, b, s, s[12:11]);
        s -= 32'h9E3779B9;
        a -= round_mix(b, d, s, s[1:0]);
      end
      r[0] = a - key_word[0]; r[1] = b - key_word[1];
      r[2] = c - key_word[2]; r[3] = d - key_word[3];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  assign pending = expected_blocks.size();

  always @(posedge clk) begin
    xtea3_pkg::block_t w;
    xtea3_pkg::block_t e;
    if (rst) begin
      for (int i = 0; i < 8; i++) key_word[i] <= '0;
      rounds_reg <= xtea3_pkg::DEFAULT_ROUNDS;
      errors = 0;
      expected_blocks.delete();
    end else begin
      if (blk_out.valid && blk_out.ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("unexpected result word", blk_out.out_word0, '0);
        end else begin
          e = expected_blocks.pop_front();
          if (blk_out.out_word0 !== e[0]) report_mismatch("out_word0", blk_out.out_word0, e[0]);
          if (blk_out.out_word1 !== e[1]) report_mismatch("out_word1", blk_out.out_word1, e[1]);
          if (blk_out.out_word2 !== e[2]) report_mismatch("out_word2", blk_out.out_word2, e[2]);
          if (blk_out.out_word3 !== e[3]) report_mismatch("out_word3", blk_out.out_word3, e[3]);
        end
      end
      if (blk_in.valid && blk_in.ready) begin
        w[0] = blk_in.block_word0; w[1] = blk_in.block_word1;
        w[2] = blk_in.block_word2; w[3] = blk_in.block_word3;
        expected_blocks.push_back(cipher_block(blk_in.req_type, w));
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          xtea3_pkg::REG_KEY_01: begin
            key_word[0] <= cfg.data[31:0]; key_word[1] <= cfg.data[63:32];
          end
          xtea3_pkg::REG_KEY_23: begin
            key_word[2] <= cfg.data[31:0]; key_word[3] <= cfg.data[63:32];
          end
          xtea3_pkg::REG_KEY_45: begin
            key_word[4] <= cfg.data[31:0]; key_word[5] <= cfg.data[63:32];
          end
          xtea3_pkg::REG_KEY_67: begin
            key_word[6] <= cfg.data[31:0]; key_word[7] <= cfg.data[63:32];
          end
          xtea3_pkg::REG_ROUNDS: rounds_reg <= cfg.data[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/xtea3_block_cipher_tb.sv =====
module xtea3_block_cipher_tb;

  logic clk;
  logic rst;
  int errors;
  int pending;
  int cycles;

  xtea3_in_if blk_in ();
  xtea3_out_if blk_out ();
  xtea3_cfg_if cfg ();

  xtea3_block_cipher dut (.clk(clk), .rst(rst), .blk_in(blk_in), .blk_out(blk_out), .cfg(cfg));
  xtea3_checker checker_i (.clk(clk), .rst(rst), .blk_in(blk_in), .blk_out(blk_out),
                           .cfg(cfg), .errors(errors), .pending(pending));

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  bit calm;
  int stall_left;

  // Receiver: random stall bursts, none once the run is calm.
  always @(posedge clk) begin
    if (rst) begin
      blk_out.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      blk_out.ready <= (stall_left == 0);
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17);
      blk_out.ready <= 1'b0;
    end else begin
      blk_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("FAIL xtea3_block_cipher");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input logic dir, input logic [31:0] w0, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] w3);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      blk_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    blk_in.valid <= 1'b1;
    blk_in.req_type <= dir;
    blk_in.block_word0 <= w0;
    blk_in.block_word1 <= w1;
    blk_in.block_word2 <= w2;
    blk_in.block_word3 <= w3;
    @(posedge clk);
    while (!blk_in.ready) @(posedge clk);
  endtask

  task automatic write_reg(input xtea3_pkg::reg_index_t idx, input logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    blk_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic random_blocks(input int count);
    for (int i = 0; i < count; i++)
      send_block(1'($urandom_range(0, 1)), pick_word(), pick_word(), pick_word(),
                 pick_word());
  endtask

  initial begin
    logic [6:0] round_set [6];
    cycles = 0;
    calm = 0;
    rst = 1'b1;
    blk_in.valid = 1'b0;
    blk_in.req_type = 1'b0;
    blk_in.block_word0 = '0;
    blk_in.block_word1 = '0;
    blk_in.block_word2 = '0;
    blk_in.block_word3 = '0;
    cfg.valid = 1'b0;
    cfg.index = xtea3_pkg::REG_KEY_01;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset key and round count.
    send_block(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_block(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_block(1'b0, 32'h80000000, 32'h1, 32'h1F, 32'hF8000000);
    drain();
    write_reg(xtea3_pkg::REG_KEY_01, 64'hFFFFFFFF_FFFFFFFF);
    write_reg(xtea3_pkg::REG_KEY_23, 64'h01234567_89ABCDEF);
    write_reg(xtea3_pkg::REG_KEY_45, 64'h0);
    write_reg(xtea3_pkg::REG_KEY_67, 64'hDEADBEEF_0BADF00D);
    // Round count zero behaves as one, and values past the maximum saturate.
    write_reg(xtea3_pkg::REG_ROUNDS, 64'h0);
    // An index past the last register is dropped.
    cfg.valid <= 1'b1;
    cfg.index <= 3'd7;
    cfg.data <= 64'h5;
    @(posedge clk);
    cfg.valid <= 1'b0;
    send_block(1'b0, 32'h12345678, 32'h0, 32'hFFFFFFFF, 32'h1);
    send_block(1'b1, 32'h12345678, 32'h0, 32'hFFFFFFFF, 32'h1);
    drain();
    write_reg(xtea3_pkg::REG_ROUNDS, 64'h7F);
    send_block(1'b0, 32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
    send_block(1'b1, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0);
    drain();

    round_set = '{7'd1, 7'd64, 7'd65, 7'd48, 7'd2, 7'd0};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(xtea3_pkg::REG_KEY_01, {$urandom, $urandom});
      write_reg(xtea3_pkg::REG_KEY_23, {$urandom, $urandom});
      write_reg(xtea3_pkg::REG_KEY_45, ph == 1 ? 64'hFFFFFFFF_FFFFFFFF : {$urandom, $urandom});
      write_reg(xtea3_pkg::REG_KEY_67, ph == 2 ? 64'h0 : {$urandom, $urandom});
      write_reg(xtea3_pkg::REG_ROUNDS, {57'h0, round_set[ph] == 7'd0
                                               ? 7'($urandom_range(1, 127))
                                               : round_set[ph]});
      if (ph == 5) calm = 1;
      random_blocks(90);
      drain();
    end

    if (errors == 0) begin
      $display("PASS xtea3_block_cipher");
    end else begin
      $display("FAIL xtea3_block_cipher");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/xtea3_pkg.sv
rtl/xtea3_if.sv
rtl/xtea3_block_cipher.sv
verif/xtea3_checker.sv
verif/xtea3_block_cipher_tb.sv
